[rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and a rotate function for the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t x, input int n);
        begin
            ror = (x >> n) | (x << (32 - n));
        end
    endfunction

endpackage

[rtl/sha_if.sv]
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       final_item;
    modport source (output valid, message_byte, byte_present, final_item, input ready);
    modport sink (input valid, message_byte, byte_present, final_item, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_done;
    modport source (output valid, digest_word, word_number, digest_done, input ready);
    modport sink (input valid, digest_word, word_number, digest_done, output ready);
endinterface

[rtl/sha256_message_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream; eight digest words per message.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  msg     | in  | message_byte[8], byte_present, final_item
//  dig     | out | digest_word[32], word_number[3], digest_done
//
//  Bytes are taken only while the hasher is idle; the 64th byte of a block
//  starts a compression (load, rounds, add). The first 16 rounds take their
//  word from the schedule RAM; a scheduled round reads w-2, w-7, w-16 and writes w.
//  A final item adds padding, one or two compressions and the output of the
//  eight digest words. Reset is asynchronous; the chaining
//  value comes up as the initial hash. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module sha256_message_hasher
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    msg,
    sha_out_if.source dig
);
    state_t      state_reg, state_next;
    logic [60:0] count_reg;
    logic [5:0]  round_reg;
    logic [1:0]  phase_reg;
    logic [3:0]  widx_reg;
    logic [2:0]  hidx_reg;
    logic        last_reg;     // final item of the message taken
    logic        two_reg;      // a second pad block follows
    word_t       wbuf_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w15_reg, w2_reg, w7_reg;

    logic        we;
    logic [3:0]  waddr, raddr;
    word_t       wdata, rdata;

    sha_ram #(.WIDTH(32), .DEPTH(16)) u_sched (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic        acc;
    logic [5:0]  pos;
    word_t       packed_w, s0, s1, wnew, t1, t2;
    logic [63:0] bits;

    assign acc      = msg.valid && msg.ready;
    assign msg.ready = (state_reg == ST_IDLE);
    assign pos      = count_reg[5:0];
    assign bits     = {count_reg, 3'b000};
    assign packed_w = (pos[1:0] == 2'd0) ? {msg.message_byte, 24'h0}
                    : wbuf_reg | (word_t'(msg.message_byte) << (8 * (3 - pos[1:0])));

    assign s0 = ror(w15_reg, 7) ^ ror(w15_reg, 18) ^ (w15_reg >> 3);
    assign s1 = ror(w2_reg, 17) ^ ror(w2_reg, 19) ^ (w2_reg >> 10);
    assign wnew = rdata + s0 + w7_reg + s1;
    assign t1 = v_reg[7] + (ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + K[round_reg]
              + ((round_reg < 6'd16) ? rdata : wnew);
    assign t2 = (ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // RAM port control: rounds >= 16 read w-2, w-7, w-16 in phases 0..2 and
    // prefetch w-15 of the next round in phase 3
    always_comb
    begin
        we    = 1'b0;
        waddr = widx_reg;
        wdata = packed_w;
        raddr = round_reg[3:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                we    = acc && msg.byte_present;
                waddr = pos[5:2];
            end
            ST_PAD:
            begin
                we    = 1'b1;
                waddr = widx_reg;
                if (widx_reg == 4'd14 && !two_reg)
                    wdata = bits[63:32];
                else if (widx_reg == 4'd15 && !two_reg)
                    wdata = bits[31:0];
                else
                    wdata = wbuf_reg;
            end
            ST_ROUND:
            begin
                if (round_reg >= 6'd16)
                begin
                    unique case (phase_reg)
                        2'd0: raddr = round_reg[3:0] - 4'd2;
                        2'd1: raddr = round_reg[3:0] - 4'd7;
                        2'd2: raddr = round_reg[3:0];
                        default: raddr = round_reg[3:0] + 4'd2;
                    endcase
                end
                else if (round_reg == 6'd15)
                    raddr = round_reg[3:0] + 4'd2;
                else
                    raddr = round_reg[3:0] + 4'd1;
                we    = (round_reg >= 6'd16) && (phase_reg == 2'd3);
                waddr = round_reg[3:0];
                wdata = wnew;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (msg.byte_present && pos == 6'd63)
                        state_next = ST_LOAD;
                    else if (msg.final_item)
                        state_next = ST_PAD;
                end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND:
                if (phase_reg == 2'd3 && round_reg == 6'd63)
                    state_next = ST_ADD;
            ST_ADD:
                if (hidx_reg == 3'd7)
                    state_next = two_reg ? ST_PAD : (last_reg ? ST_OUT : ST_IDLE);
            ST_PAD:
                if (widx_reg == 4'd15)
                    state_next = ST_LOAD;
            ST_OUT:
                if (dig.ready && hidx_reg == 3'd7)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dig.valid       = (state_reg == ST_OUT);
        dig.digest_word = h_reg[hidx_reg];
        dig.word_number = hidx_reg;
        dig.digest_done = (hidx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            round_reg <= '0;
            phase_reg <= '0;
            widx_reg  <= '0;
            hidx_reg  <= '0;
            last_reg  <= 1'b0;
            two_reg   <= 1'b0;
            wbuf_reg  <= '0;
            w15_reg   <= '0;
            w2_reg    <= '0;
            w7_reg    <= '0;
            v_reg     <= '{default: '0};
            h_reg     <= IV;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        last_reg <= msg.final_item;
                        if (msg.byte_present)
                        begin
                            count_reg <= count_reg + 61'd1;
                            wbuf_reg  <= packed_w;
                        end
                        // pad begins right after the final byte
                        if (msg.final_item)
                        begin
                            logic [5:0] p;
                            p = msg.byte_present ? pos + 6'd1 : pos;
                            widx_reg <= p[5:2];
                            // a full block goes out first, then a pad-only block
                            two_reg  <= (p >= 6'd56) || (msg.byte_present && pos == 6'd63);
                            if (p[1:0] == 2'd0)
                                wbuf_reg <= {PAD_BYTE, 24'h0};
                            else if (msg.byte_present)
                                wbuf_reg <= packed_w | (word_t'(PAD_BYTE) << (8 * (3 - p[1:0])));
                            else
                                wbuf_reg <= wbuf_reg | (word_t'(PAD_BYTE) << (8 * (3 - p[1:0])));
                        end
                    end
                    round_reg <= '0;
                    phase_reg <= '0;
                    hidx_reg  <= '0;
                end
                ST_PAD:
                begin
                    wbuf_reg <= '0;
                    widx_reg <= widx_reg + 4'd1;
                    round_reg <= '0;
                    phase_reg <= '0;
                end
                ST_LOAD:
                begin
                    v_reg <= h_reg;
                end
                ST_ROUND:
                begin
                    if (round_reg < 6'd16 || phase_reg == 2'd3)
                    begin
                        v_reg[7] <= v_reg[6];
                        v_reg[6] <= v_reg[5];
                        v_reg[5] <= v_reg[4];
                        v_reg[4] <= v_reg[3] + t1;
                        v_reg[3] <= v_reg[2];
                        v_reg[2] <= v_reg[1];
                        v_reg[1] <= v_reg[0];
                        v_reg[0] <= t1 + t2;
                        // every round restarts at phase 0; the first scheduled round takes w-15 from round 15's read
                        if (round_reg < 6'd15)
                            phase_reg <= 2'd0;
                        else
                            phase_reg <= 2'd0;
                        round_reg <= round_reg + 6'd1;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                    unique case (phase_reg)
                        2'd0: w15_reg <= rdata;
                        2'd1: w2_reg  <= rdata;
                        2'd2: w7_reg  <= rdata;
                        default: ;
                    endcase
                    hidx_reg <= '0;
                end
                ST_ADD:
                begin
                    h_reg[hidx_reg] <= h_reg[hidx_reg] + v_reg[hidx_reg];
                    hidx_reg <= hidx_reg + 3'd1;
                    if (hidx_reg == 3'd7)
                    begin
                        if (two_reg && last_reg)
                        begin
                            two_reg  <= 1'b0;
                            widx_reg <= '0;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (dig.ready)
                    begin
                        hidx_reg <= hidx_reg + 3'd1;
                        if (hidx_reg == 3'd7)
                        begin
                            h_reg     <= IV;
                            count_reg <= '0;
                            last_reg  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !msg.ready) else $error("ready while busy");
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid |-> last_reg) else $error("digest outside final");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD && $past(state_reg) == ST_ROUND |-> $past(round_reg) == 6'd63)
        else $error("compression cut short");
`endif
endmodule

[rtl/sha_ram.sv]
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
